[design/kar_pkg.sv]
package kar_pkg;

    localparam int TIME_W    = 24;  // held-time accumulator and thresholds
    localparam int KEY_W     = 7;   // key index field
    localparam int ELAPSED_W = 16;  // scan interval field
    localparam int KEY_EXT_W = 9;   // key index widened to hold a key count up to 256

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [TIME_W-1:0] FIRST_DELAY_RST   = 24'd500000;
    localparam logic [TIME_W-1:0] REPEAT_PERIOD_RST = 24'd100000;

    // config register indexes
    localparam logic CFG_FIRST_DELAY   = 1'b0;
    localparam logic CFG_REPEAT_PERIOD = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_FIRST       = 3'd1,
        PH_REPEAT      = 3'd2,
        PH_WAIT_DELAY  = 3'd4,
        PH_WAIT_PERIOD = 3'd5
    } t_phase;

    // one entry of the per-key state table
    typedef struct packed {
        t_phase              phase;
        logic [TIME_W-1:0]   held;
    } t_entry;

    localparam t_entry ENTRY_RST = '{phase: PH_IDLE, held: '0};

endpackage

[design/kar_update.sv]
module kar_update (
    input  kar_pkg::t_entry                 i_entry,
    input  logic                            i_key_down,
    input  logic [kar_pkg::ELAPSED_W-1:0]   i_elapsed,
    input  logic [kar_pkg::TIME_W-1:0]      i_first_delay,
    input  logic [kar_pkg::TIME_W-1:0]      i_repeat_period,
    output kar_pkg::t_entry                 o_entry,
    output logic                            o_fire
);
    import kar_pkg::*;

    logic [TIME_W:0]   w_sum;
    logic [TIME_W-1:0] w_held;

    // saturating accumulate
    assign w_sum  = {1'b0, i_entry.held} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, i_elapsed};
    assign w_held = w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];

    always_comb begin
        o_entry = ENTRY_RST;
        if (i_key_down) begin
            o_entry.held = w_held;
            unique case (i_entry.phase)
                PH_FIRST, PH_WAIT_DELAY: begin
                    if (w_held >= i_first_delay) begin
                        o_entry.phase = PH_REPEAT;
                        o_entry.held  = '0;
                    end else begin
                        o_entry.phase = PH_WAIT_DELAY;
                    end
                end
                PH_REPEAT, PH_WAIT_PERIOD: begin
                    if (w_held >= i_repeat_period) begin
                        o_entry.phase = PH_REPEAT;
                        o_entry.held  = '0;
                    end else begin
                        o_entry.phase = PH_WAIT_PERIOD;
                    end
                end
                default: begin
                    // idle and unused codes: fresh press
                    o_entry.phase = PH_FIRST;
                end
            endcase
        end
    end

    assign o_fire = i_key_down &&
                    (o_entry.phase == PH_FIRST || o_entry.phase == PH_REPEAT);

endmodule

[design/key_auto_repeat_qualifier_core.sv]
// Key auto-repeat qualifier.
// Input stream (s_*): one beat per key scan sample, tdata = {elapsed, key_down,
// key_index}. Output stream (m_*): one beat per input beat, in order,
// tdata = {fire, key_echo}. fire is high on the first held scan of a key, once
// more when its held time reaches first_delay, then once every repeat_period.
// Config port: i_cfg_we with i_cfg_idx 0 = first_delay, 1 = repeat_period;
// write only while no beat is in flight.
// Per-key state (phase + 24-bit held time) lives in a KEY_COUNT-deep table with
// a registered read. Stage 0 issues the read on accept, stage 1 updates
// and writes back; a back-to-back beat on the same key picks up the write
// through a one-entry forward register.
// A beat is registered in stage 1, then in the output register. Throughput:
// 1 beat/cycle while m_tready is high, set by the single table read/modify/write.
// Reset: all keys read as idle with zero held time (per-entry valid flops are
// cleared at once, no sweep), registers return to their defaults, both
// pipeline stages empty.
// Stall: when m_tready is low a full output register holds, stage 1 holds its
// beat behind it, and s_tready drops only once both are occupied.
module key_auto_repeat_qualifier_core #(
    parameter int KEY_COUNT = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [kar_pkg::TIME_W-1:0]  i_cfg_wdata,
    // scan samples
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // [6:0] key_index, [7] key_down, [23:8] elapsed
    // qualified results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // [6:0] key_echo, [7] fire
);
    import kar_pkg::*;

    localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    // config registers
    logic [TIME_W-1:0] r_first_delay;
    logic [TIME_W-1:0] r_repeat_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay   <= FIRST_DELAY_RST;
            r_repeat_period <= REPEAT_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_DELAY:   r_first_delay   <= i_cfg_wdata;
                CFG_REPEAT_PERIOD: r_repeat_period <= i_cfg_wdata;
                default:           r_first_delay   <= r_first_delay;
            endcase
        end
    end

    // input unpack
    logic [KEY_W-1:0]     w_key;
    logic                 w_down;
    logic [ELAPSED_W-1:0] w_elapsed;
    logic [KEY_EXT_W-1:0] w_key_ext;
    logic                 w_in_range;
    logic [AW-1:0]        w_rd_addr;

    assign w_key      = s_tdata[6:0];
    assign w_down     = s_tdata[7];
    assign w_elapsed  = s_tdata[23:8];
    assign w_key_ext  = {{(KEY_EXT_W - KEY_W){1'b0}}, w_key};
    assign w_in_range = w_key_ext < KEY_EXT_W'(KEY_COUNT);
    assign w_rd_addr  = w_key_ext[AW-1:0];

    // pipeline control
    logic r_s1_vld;
    logic r_m_vld;
    logic w_s1_adv;
    logic w_accept;

    assign w_s1_adv = r_s1_vld && (!r_m_vld || m_tready);
    assign s_tready = !r_s1_vld || w_s1_adv;
    assign w_accept = s_tvalid && s_tready;

    // stage 1 payload
    logic [KEY_W-1:0]     r_s1_key;
    logic                 r_s1_down;
    logic [ELAPSED_W-1:0] r_s1_elapsed;
    logic                 r_s1_inr;
    logic [AW-1:0]        r_s1_addr;

    // state table, valid flops and forward path
    t_entry               mem [KEY_COUNT];
    logic [KEY_COUNT-1:0] r_valid;
    t_entry               r_rd_data;
    logic                 r_rd_vld;
    logic                 r_fwd_hit;
    t_entry               r_fwd_data;

    logic   w_wr_en;
    t_entry w_cur;
    t_entry w_next;
    logic   w_fire;

    assign w_wr_en = w_s1_adv && r_s1_inr;

    always_comb begin
        priority if (r_fwd_hit) begin
            w_cur = r_fwd_data;
        end else if (r_rd_vld) begin
            w_cur = r_rd_data;
        end else begin
            w_cur = ENTRY_RST;
        end
    end

    kar_update u_update (
        .i_entry         (w_cur),
        .i_key_down      (r_s1_down),
        .i_elapsed       (r_s1_elapsed),
        .i_first_delay   (r_first_delay),
        .i_repeat_period (r_repeat_period),
        .o_entry         (w_next),
        .o_fire          (w_fire)
    );

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_s1_addr] <= w_next;
        end
        if (w_accept) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_wr_en) begin
            r_valid[r_s1_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_vld     <= r_valid[w_rd_addr];
            // same-key write in this cycle is missed by the read: forward it
            r_fwd_hit    <= w_wr_en && (r_s1_addr == w_rd_addr);
            r_fwd_data   <= w_next;
            r_s1_key     <= w_key;
            r_s1_down    <= w_down;
            r_s1_elapsed <= w_elapsed;
            r_s1_inr     <= w_in_range;
            r_s1_addr    <= w_rd_addr;
        end
    end

    // output register
    logic [KEY_W-1:0] r_m_key;
    logic             r_m_fire;
    logic             n_s1_vld;
    logic             n_m_vld;

    assign n_s1_vld = w_accept || (r_s1_vld && !w_s1_adv);
    assign n_m_vld  = w_s1_adv || (r_m_vld && !m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_m_vld  <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_m_vld  <= n_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_m_key  <= r_s1_key;
            r_m_fire <= r_s1_inr && w_fire;
        end
    end

    assign m_tvalid = r_m_vld;
    assign m_tdata  = {r_m_fire, r_m_key};

endmodule

[design/kar_checker.sv]
module kar_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output beat valid right after reset");

    // stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    // with the output register empty the pipe can always take a beat
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a fresh output beat was taken in and passed on without a stall
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output beat without matching input beat");

endmodule

bind key_auto_repeat_qualifier_core kar_checker u_kar_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[test/tb_key_auto_repeat_qualifier_core.sv]
module tb_key_auto_repeat_qualifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    import kar_pkg::*;

    localparam int KEY_COUNT = 128;

    // one scan sample, laid out exactly as s_tdata (key_index in the low bits)
    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        logic                 down;
        logic [KEY_W-1:0]     key;
    } t_scan;

    // one qualified result, laid out as m_tdata
    typedef struct packed {
        logic             fire;
        logic [KEY_W-1:0] key;
    } t_qual;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_idx   = CFG_FIRST_DELAY;
    logic [TIME_W-1:0]   i_cfg_wdata = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata     = '0;  // [6:0] key_index, [7] key_down, [23:8] elapsed
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [7:0]          m_tdata;           // [6:0] key_echo, [7] fire

    // scan samples waiting to be driven, filled by the sequencing block
    t_scan scan_q[$];
    // qualified results the block still owes, oldest first
    t_qual owed_q[$];

    // shadow of the per-key state table and the two timing registers
    t_phase            key_phase_tbl[KEY_COUNT];
    logic [TIME_W-1:0] key_held_tbl[KEY_COUNT];
    logic [TIME_W-1:0] first_delay_reg   = FIRST_DELAY_RST;
    logic [TIME_W-1:0] repeat_period_reg = REPEAT_PERIOD_RST;

    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    int   hold_req     = 0;   // bumped to ask the receiver for a long hold-off
    int   hold_ack     = 0;
    int   hold_left    = 0;
    logic beat_taken   = 1'b0;  // input beat accepted at the last rising edge
    int   mismatches   = 0;

    key_auto_repeat_qualifier_core #(
        .KEY_COUNT (KEY_COUNT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t ns: MISMATCH %s", $realtime, what);
    endtask

    // Typematic step for one scan sample: updates the shadow table and gives
    // the result the block must return for it.
    task automatic qualify_scan(input t_scan s, output t_qual r);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] t;
        t_phase            nxt;
        r.key  = s.key;
        r.fire = 1'b0;
        // keys beyond the table change nothing and never fire
        if (int'(s.key) >= KEY_COUNT)
            return;
        // release: back to idle, accumulator cleared
        if (!s.down) begin
            key_phase_tbl[s.key] = PH_IDLE;
            key_held_tbl[s.key]  = '0;
            return;
        end
        // held: accumulate, saturating at the top of the 24-bit range
        sum = {1'b0, key_held_tbl[s.key]} + {{(TIME_W+1-ELAPSED_W){1'b0}}, s.elapsed};
        t   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        case (key_phase_tbl[s.key])
            PH_FIRST, PH_WAIT_DELAY: begin
                if (t >= first_delay_reg) begin
                    nxt = PH_REPEAT;
                    t   = '0;
                end else begin
                    nxt = PH_WAIT_DELAY;
                end
            end
            PH_REPEAT, PH_WAIT_PERIOD: begin
                if (t >= repeat_period_reg) begin
                    nxt = PH_REPEAT;
                    t   = '0;
                end else begin
                    nxt = PH_WAIT_PERIOD;
                end
            end
            // idle, and any stray code, counts as a fresh press
            default: nxt = PH_FIRST;
        endcase
        key_phase_tbl[s.key] = nxt;
        key_held_tbl[s.key]  = t;
        r.fire = (nxt == PH_FIRST) || (nxt == PH_REPEAT);
    endtask

    // Monitor: both handshakes are sampled at the rising edge. Inputs are
    // predicted on acceptance, before the output side is checked, so an
    // expectation always exists ahead of its result.
    always @(posedge i_clk) begin
        t_qual want;
        t_qual got;
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                key_phase_tbl[k] = PH_IDLE;
                key_held_tbl[k]  = '0;
            end
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                qualify_scan(t_scan'(s_tdata), want);
                owed_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = t_qual'(m_tdata);
                if (owed_q.size() == 0) begin
                    flag_mismatch($sformatf("result beat key=%0d fire=%0b with none owed",
                                            got.key, got.fire));
                end else begin
                    want = owed_q.pop_front();
                    if (got.key !== want.key)
                        flag_mismatch($sformatf("key_echo got %0d want %0d",
                                                got.key, want.key));
                    if (got.fire !== want.fire)
                        flag_mismatch($sformatf("fire for key %0d got %b want %b",
                                                want.key, got.fire, want.fire));
                end
            end
        end
    end

    // Driver: a new beat goes out only once the current one has been taken,
    // so tvalid never drops while a beat is on offer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || beat_taken) begin
            if (scan_q.size() == 0 || $urandom_range(0, 99) < snd_idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tdata  <= scan_q.pop_front();
                s_tvalid <= 1'b1;
            end
        end
    end

    // Receiver: random back-pressure, plus an occasional long hold-off that
    // lets the pipeline fill and push back on the input side.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= 80;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task automatic queue_scan(input logic [KEY_W-1:0] key, input logic down,
                              input logic [ELAPSED_W-1:0] dt);
        t_scan s;
        s.key     = key;
        s.down    = down;
        s.elapsed = dt;
        scan_q.push_back(s);
    endtask

    // Register write, only issued while nothing is in flight.
    task automatic write_reg(input logic idx, input logic [TIME_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_FIRST_DELAY)
            first_delay_reg = val;
        else
            repeat_period_reg = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold the sender back until every owed result is out, then let the
    // two-stage pipeline settle.
    task automatic wait_drained();
        while (scan_q.size() != 0 || s_tvalid || owed_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Scan interval: mostly scaled to the current thresholds so keys move
    // through delay and repeat within a short hold, sometimes the extremes or any value.
    function automatic logic [ELAPSED_W-1:0] pick_elapsed(input int span);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return ELAPSED_W'($urandom_range(0, 65535));
            default: return ELAPSED_W'($urandom_range(0, span));
        endcase
    endfunction

    // Typing traffic: a handful of keys held for random stretches and then
    // (usually) released, interleaved scan by scan, with some noise beats.
    task automatic queue_typing(input int n_items);
        int               span;
        int               target;
        int               s;
        int               left[4];
        logic [KEY_W-1:0] held_key[4];
        span   = (int'(first_delay_reg) + int'(repeat_period_reg)) / 6;
        span   = (span < 1) ? 1 : (span > 65535) ? 65535 : span;
        target = scan_q.size() + n_items;
        for (int i = 0; i < 4; i++) begin
            held_key[i] = KEY_W'($urandom_range(0, KEY_COUNT - 1));
            left[i]     = $urandom_range(0, 20);
        end
        while (scan_q.size() < target) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_scan(KEY_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                           ELAPSED_W'($urandom_range(0, 65535)));
            end else begin
                s = $urandom_range(0, 3);
                if (left[s] == 0) begin
                    // occasionally skip the release so the key carries on
                    if ($urandom_range(0, 9) != 0)
                        queue_scan(held_key[s], 1'b0, pick_elapsed(span));
                    held_key[s] = KEY_W'($urandom_range(0, KEY_COUNT - 1));
                    left[s]     = $urandom_range(1, 20);
                end else begin
                    queue_scan(held_key[s], 1'b1, pick_elapsed(span));
                    left[s]--;
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- sender idles lightly, receiver heavily ----
        snd_idle_pct = 14;
        rcv_idle_pct = 78;

        // Directed, at reset timing (500000 / 100000). Key 0: first press,
        // eight max-interval scans to the delay, two more to the first repeat,
        // all back to back on one key to exercise the forwarding path.
        queue_scan(7'd0, 1'b1, 16'd0);
        repeat (8) queue_scan(7'd0, 1'b1, 16'hFFFF);
        repeat (2) queue_scan(7'd0, 1'b1, 16'hFFFF);
        queue_scan(7'd0, 1'b0, 16'hFFFF);
        // top key, alternating bit patterns, release of an idle key
        queue_scan(7'd127, 1'b1, 16'd0);
        queue_scan(7'd85, 1'b1, 16'hAAAA);
        queue_scan(7'd42, 1'b1, 16'h5555);
        queue_scan(7'd85, 1'b1, 16'h5555);
        queue_scan(7'd127, 1'b0, 16'd0);
        queue_scan(7'd42, 1'b0, 16'hAAAA);
        queue_scan(7'd99, 1'b0, 16'd1);
        // release then re-press: must fire as a fresh key
        queue_scan(7'd0, 1'b1, 16'd1);
        wait_drained();

        write_reg(CFG_FIRST_DELAY, TIME_W'($urandom_range(1000, 300000)));
        write_reg(CFG_REPEAT_PERIOD, TIME_W'($urandom_range(1000, 100000)));
        queue_typing(150);
        hold_req++;             // long receiver stall while beats keep coming
        wait_drained();         // sender pauses until every result is back
        queue_typing(150);
        wait_drained();
        write_reg(CFG_FIRST_DELAY, TIME_W'($urandom_range(1, 200000)));
        write_reg(CFG_REPEAT_PERIOD, TIME_W'($urandom_range(1, 50000)));
        queue_typing(100);
        wait_drained();

        // ---- sender idles heavily, receiver lightly ----
        snd_idle_pct = 78;
        rcv_idle_pct = 14;

        // zero delay and period: every held scan after the press fires
        write_reg(CFG_FIRST_DELAY, '0);
        write_reg(CFG_REPEAT_PERIOD, '0);
        queue_typing(200);
        hold_req++;
        wait_drained();

        // maximum thresholds: only a saturated accumulator reaches the delay,
        // which takes 257 max-interval scans
        write_reg(CFG_FIRST_DELAY, TIME_MAX);
        write_reg(CFG_REPEAT_PERIOD, TIME_MAX);
        repeat (259) queue_scan(7'd3, 1'b1, 16'hFFFF);
        queue_scan(7'd3, 1'b0, 16'd0);
        queue_typing(100);
        wait_drained();

        // ---- no idling on either side ----
        snd_idle_pct = 0;
        rcv_idle_pct = 0;

        write_reg(CFG_FIRST_DELAY, 24'd1);
        write_reg(CFG_REPEAT_PERIOD, TIME_W'($urandom_range(1, 150000)));
        queue_typing(200);
        wait_drained();
        write_reg(CFG_FIRST_DELAY, TIME_W'($urandom_range(1000, 400000)));
        write_reg(CFG_REPEAT_PERIOD, TIME_W'($urandom_range(0, 80000)));
        queue_typing(200);
        wait_drained();
        // full-range thresholds: mostly first presses only
        write_reg(CFG_FIRST_DELAY, TIME_W'($urandom_range(0, 24'hFFFFFF)));
        write_reg(CFG_REPEAT_PERIOD, TIME_W'($urandom_range(0, 24'hFFFFFF)));
        queue_typing(100);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && owed_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
